// ===== hw/rtl/neighbor_cell_enumerator_unit_defines.svh =====
// Assertion macros used by the checker file of the neighbor cell enumerator.
`ifndef NEIGHBOR_CELL_ENUMERATOR_UNIT_DEFINES_SVH
`define NEIGHBOR_CELL_ENUMERATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/nce_pkg.sv =====
package nce_pkg;

	// Width of a grid index: three 16-bit counts multiply to at most 48 bits.
	localparam int GRID_BITS    = 48;
	localparam int COUNT_BITS   = 16;
	localparam int DIMS_BITS    = 2;
	localparam int CFG_IDX_BITS = 2;
	localparam int DIV_CNT_BITS = $clog2(GRID_BITS + 1);

	localparam logic [CFG_IDX_BITS-1:0] REG_DIMS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_DIM0  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_DIM1  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_DIM2  = 2'd3;

	// Per-dimension choice: stay, first neighbor, second neighbor.
	localparam logic [1:0] OPT_CENTER = 2'd0;
	localparam logic [1:0] OPT_FIRST  = 2'd1;
	localparam logic [1:0] OPT_SECOND = 2'd2;

	typedef struct packed {
		logic [DIMS_BITS-1:0]  dims_in_use;
		logic [COUNT_BITS-1:0] count0;
		logic [COUNT_BITS-1:0] count1;
		logic [COUNT_BITS-1:0] count2;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic div0_start;
		logic div1_start;
		logic odo_init;
		logic emit;
		logic emit_oor;
	} cmd_t;

	typedef struct packed {
		logic out_of_range;
		logic div_done;
		logic last;
	} status_t;

endpackage

// ===== hw/rtl/nce_cfg_regs.sv =====
module nce_cfg_regs
	import nce_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COUNT_BITS-1:0]   cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dims_in_use <= DIMS_BITS'(3);
			cfg_q.count0      <= COUNT_BITS'(1);
			cfg_q.count1      <= COUNT_BITS'(1);
			cfg_q.count2      <= COUNT_BITS'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DIMS_IN_USE: cfg_q.dims_in_use <= cfg_data[DIMS_BITS-1:0];
				REG_COUNT_DIM0:  cfg_q.count0 <= cfg_data;
				REG_COUNT_DIM1:  cfg_q.count1 <= cfg_data;
				REG_COUNT_DIM2:  cfg_q.count2 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/nce_div.sv =====
module nce_div
	import nce_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [GRID_BITS-1:0]  dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  done,
	output logic [GRID_BITS-1:0]  quotient,
	output logic [COUNT_BITS-1:0] remainder
);

	// Restoring division, one quotient bit per cycle, MSB first.
	// The divisor is captured at start, so the input may change while the division runs.
	logic [GRID_BITS-1:0]    quot_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [COUNT_BITS-1:0]   dvsr_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    run_q;
	logic                    done_q;
	logic [COUNT_BITS:0]     shifted;
	logic                    ge;
	logic [COUNT_BITS:0]     diff;

	assign shifted = {rem_q, quot_q[GRID_BITS-1]};
	assign ge      = (shifted >= {1'b0, dvsr_q});
	assign diff    = shifted - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(GRID_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[GRID_BITS-2:0], ge};
			rem_q  <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/nce_datapath.sv =====
module nce_datapath
	import nce_pkg::*;
#(
	parameter int MAX_DIMS        = 3,
	parameter int CELL_INDEX_BITS = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic [CELL_INDEX_BITS-1:0] cell_index,
	input  cmd_t                       cmd,
	output status_t                    status,
	output logic                       result_valid,
	output logic [CELL_INDEX_BITS-1:0] neighbor_cell_index,
	output logic                       last_neighbor,
	output logic                       index_out_of_range
);

	localparam int WORK_BITS = (CELL_INDEX_BITS > GRID_BITS) ? CELL_INDEX_BITS : GRID_BITS;

	logic [CELL_INDEX_BITS-1:0]   center_q;
	logic [COUNT_BITS-1:0]        n0_q, n1_q, n2_q;
	logic [2*COUNT_BITS-1:0]      prod01_q;
	logic [GRID_BITS-1:0]         total_q;
	logic                         lo0_q, hi0_q, lo1_q, hi1_q, lo2_q, hi2_q;
	logic [1:0]                   a0_q, a1_q, a2_q;
	logic [CELL_INDEX_BITS-1:0]   out_idx_q;
	logic                         out_last_q, out_oor_q, valid_q;

	logic [DIMS_BITS-1:0]         dims_eff;
	logic [WORK_BITS-1:0]         center_w;
	logic [GRID_BITS-1:0]         center_g;
	logic                         div_start, div_done;
	logic [GRID_BITS-1:0]         div_dividend, div_quot;
	logic [COUNT_BITS-1:0]        div_divisor, div_rem;
	logic                         last0, last1, last2;
	logic [1:0]                   pre0_nxt, pre1_nxt;
	logic [GRID_BITS-1:0]         off0, off1, off2, sum_g;
	logic [WORK_BITS-1:0]         sum_w;

	assign dims_eff = (cfg.dims_in_use > DIMS_BITS'(MAX_DIMS)) ? DIMS_BITS'(MAX_DIMS)
		: cfg.dims_in_use;
	assign center_w = WORK_BITS'(center_q);
	assign center_g = center_w[GRID_BITS-1:0];

	function automatic logic [GRID_BITS-1:0] offset(input logic [1:0] opt, input logic lo,
			input logic [GRID_BITS-1:0] stride);
		logic [GRID_BITS-1:0] r;
		case (opt)
			OPT_CENTER: r = '0;
			OPT_FIRST:  r = lo ? (~stride + GRID_BITS'(1)) : stride;
			default:    r = stride;
		endcase
		return r;
	endfunction

	function automatic logic upper_exists(input logic [COUNT_BITS-1:0] digit,
			input logic [COUNT_BITS-1:0] count);
		return ({1'b0, digit} + (COUNT_BITS+1)'(1)) < {1'b0, count};
	endfunction

	// Unused dimensions count as size one, so they add no neighbors.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			center_q <= cell_index;
			n0_q <= (dims_eff >= DIMS_BITS'(1)) ? cfg.count0 : COUNT_BITS'(1);
			n1_q <= (dims_eff >= DIMS_BITS'(2)) ? cfg.count1 : COUNT_BITS'(1);
			n2_q <= (dims_eff >= DIMS_BITS'(3)) ? cfg.count2 : COUNT_BITS'(1);
		end
		if (cmd.mul1) begin
			prod01_q <= n0_q * n1_q;
		end
		if (cmd.mul2) begin
			total_q <= GRID_BITS'(prod01_q * n2_q);
		end
		if (cmd.div1_start) begin
			lo0_q <= (div_rem != '0);
			hi0_q <= upper_exists(div_rem, n0_q);
		end
		if (cmd.odo_init) begin
			lo1_q <= (div_rem != '0);
			hi1_q <= upper_exists(div_rem, n1_q);
			lo2_q <= (div_quot[COUNT_BITS-1:0] != '0);
			hi2_q <= upper_exists(div_quot[COUNT_BITS-1:0], n2_q);
		end
	end

	assign status.out_of_range = (center_w >= WORK_BITS'(total_q));
	assign status.div_done     = div_done;

	assign div_start    = cmd.div0_start | cmd.div1_start;
	assign div_dividend = cmd.div1_start ? div_quot : center_g;
	assign div_divisor  = cmd.div1_start ? n1_q : n0_q;

	nce_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Per-dimension choices walked in breadth-first list order. The cells that move only
	// in dimensions 0 and 1 come first: dimension 0 alone, then for each dimension 0
	// choice its dimension 1 neighbors. After that, each of those cells in the same order
	// takes its dimension 2 neighbors.
	assign last0 = (a0_q == (2'(lo0_q) + 2'(hi0_q)));
	assign last1 = (a1_q == (2'(lo1_q) + 2'(hi1_q)));
	assign last2 = (a2_q == (2'(lo2_q) + 2'(hi2_q)));
	assign status.last = last0 & last1 & last2;

	// Next pair of dimension 0 and 1 choices in list order.
	always_comb begin
		pre0_nxt = a0_q;
		pre1_nxt = a1_q;
		if (a1_q == OPT_CENTER) begin
			if (!last0) begin
				pre0_nxt = a0_q + 2'd1;
			end else begin
				pre0_nxt = OPT_CENTER;
				pre1_nxt = OPT_FIRST;
			end
		end else if (!last1) begin
			pre1_nxt = a1_q + 2'd1;
		end else begin
			pre0_nxt = a0_q + 2'd1;
			pre1_nxt = OPT_FIRST;
		end
	end

	assign off0  = offset(a0_q, lo0_q, GRID_BITS'(1));
	assign off1  = offset(a1_q, lo1_q, GRID_BITS'(n0_q));
	assign off2  = offset(a2_q, lo2_q, GRID_BITS'(prod01_q));
	assign sum_g = center_g + off0 + off1 + off2;
	assign sum_w = WORK_BITS'(sum_g);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a0_q <= OPT_CENTER;
			a1_q <= OPT_CENTER;
			a2_q <= OPT_CENTER;
		end else if (cmd.odo_init) begin
			a0_q <= OPT_CENTER;
			a1_q <= OPT_CENTER;
			a2_q <= OPT_CENTER;
		end else if (cmd.emit) begin
			if (a2_q == OPT_CENTER) begin
				if (last0 && last1) begin
					a0_q <= OPT_CENTER;
					a1_q <= OPT_CENTER;
					a2_q <= OPT_FIRST;
				end else begin
					a0_q <= pre0_nxt;
					a1_q <= pre1_nxt;
				end
			end else if (!last2) begin
				a2_q <= a2_q + 2'd1;
			end else begin
				a0_q <= pre0_nxt;
				a1_q <= pre1_nxt;
				a2_q <= OPT_FIRST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit | cmd.emit_oor;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_oor) begin
			out_idx_q  <= '0;
			out_last_q <= 1'b1;
			out_oor_q  <= 1'b1;
		end else if (cmd.emit) begin
			out_idx_q  <= sum_w[CELL_INDEX_BITS-1:0];
			out_last_q <= status.last;
			out_oor_q  <= 1'b0;
		end
	end

	assign result_valid        = valid_q;
	assign neighbor_cell_index = out_idx_q;
	assign last_neighbor       = out_last_q;
	assign index_out_of_range  = out_oor_q;

endmodule

// ===== hw/rtl/nce_ctrl.sv =====
module nce_ctrl
	import nce_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL1  = 3'd1;
	localparam logic [2:0] ST_MUL2  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DIV0  = 3'd4;
	localparam logic [2:0] ST_DIV1  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.out_of_range) begin
					cmd.emit_oor = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.div0_start = 1'b1;
					state_d        = ST_DIV0;
				end
			end
			ST_DIV0: begin
				if (status.div_done) begin
					cmd.div1_start = 1'b1;
					state_d        = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (status.div_done) begin
					cmd.odo_init = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/neighbor_cell_enumerator_unit.sv =====
// Neighbor cell enumerator.
// A transaction starts at a rising edge where start is high and busy is low; cell_index is
// sampled there. The block then lists the center cell and every neighbor one step away
// along each used dimension, one result per cycle, breadth first: for each dimension in
// turn, each listed cell adds its lower and then its upper neighbor if it lies in the grid.
// Each result is shown for exactly one cycle with result_valid high; the receiver cannot
// stall, so results are never held back. last_neighbor marks the final result.
// An index at or beyond the grid size gives one result with index_out_of_range set,
// registered from the range check that follows the load and the two multiplies that
// give the grid size. In range, the range check starts two restoring divisions (one
// quotient bit per cycle, run one after the other) that split the index into
// per-dimension digits; the first result follows them and the rest follow back to back.
// busy falls in the cycle that shows the last result, so the next start may be taken then.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once; the user
// must make them only while the block is idle, as the block itself does not enforce it.
// Reset sets three used dimensions and all counts to one, and returns the controller to
// idle with no result pending.
module neighbor_cell_enumerator_unit
	import nce_pkg::*;
#(
	parameter int MAX_DIMS        = 3,
	parameter int CELL_INDEX_BITS = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [COUNT_BITS-1:0]      cfg_data,
	input  logic                       start,
	output logic                       busy,
	input  logic [CELL_INDEX_BITS-1:0] cell_index,
	output logic                       result_valid,
	output logic [CELL_INDEX_BITS-1:0] neighbor_cell_index,
	output logic                       last_neighbor,
	output logic                       index_out_of_range
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// Configuration registers; the datapath samples them when a transaction starts.
	nce_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The controller sequences the multiplies, range check, divisions and the emit phase.
	nce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the operands, the divider, the neighbor odometer and the
	// registered result ports.
	nce_datapath #(
		.MAX_DIMS        (MAX_DIMS),
		.CELL_INDEX_BITS (CELL_INDEX_BITS)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg),
		.cell_index          (cell_index),
		.cmd                 (cmd),
		.status              (status),
		.result_valid        (result_valid),
		.neighbor_cell_index (neighbor_cell_index),
		.last_neighbor       (last_neighbor),
		.index_out_of_range  (index_out_of_range)
	);

endmodule

// ===== hw/rtl/nce_checker.sv =====
`include "neighbor_cell_enumerator_unit_defines.svh"

module nce_checker #(
	parameter int CELL_INDEX_BITS = 48
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       result_valid,
	input logic [CELL_INDEX_BITS-1:0] neighbor_cell_index,
	input logic                       last_neighbor,
	input logic                       index_out_of_range
);

	// A result that is not the last one is followed directly by the next one.
	`NCE_ASSERT_NEXT(a_burst_contiguous, clk, arst_n, result_valid && !last_neighbor, result_valid, "result burst broken before its last result")

	// The block stays busy while more results of the transaction are due.
	`NCE_ASSERT_SAME(a_busy_in_burst, clk, arst_n, result_valid && !last_neighbor, busy, "busy dropped inside a result burst")

	// An accepted transaction makes the block busy.
	`NCE_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy, "busy not raised after an accepted transaction")

	// An out-of-range result is a single, last result carrying index zero.
	`NCE_ASSERT_SAME(a_oor_result, clk, arst_n, result_valid && index_out_of_range, last_neighbor && (neighbor_cell_index == '0), "out-of-range result malformed")

endmodule

bind neighbor_cell_enumerator_unit nce_checker #(
	.CELL_INDEX_BITS (CELL_INDEX_BITS)
) u_nce_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.start               (start),
	.busy                (busy),
	.result_valid        (result_valid),
	.neighbor_cell_index (neighbor_cell_index),
	.last_neighbor       (last_neighbor),
	.index_out_of_range  (index_out_of_range)
);
